>>> design/jlk_pkg.sv
// Shared types, codes and helpers for the jerk-limited kinematics step block.
// Used by the top level and jlk_lane; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package jlk_pkg;

	localparam int unsigned AXIS_MAX = 3;
	localparam int unsigned DEF_AXIS_COUNT = 3;

	localparam logic [2:0] REG_JERK_LIMIT  = 3'd0;
	localparam logic [2:0] REG_ACCEL_LIMIT = 3'd1;
	localparam logic [2:0] REG_SPEED_LIMIT = 3'd2;
	localparam logic [2:0] REG_TICK_RATE   = 3'd3;
	localparam logic [2:0] REG_MODE_X      = 3'd4;
	localparam logic [2:0] REG_MODE_Y      = 3'd5;
	localparam logic [2:0] REG_MODE_Z      = 3'd6;

	localparam logic [1:0] MODE_STILL       = 2'd0;
	localparam logic [1:0] MODE_CONST_ACCEL = 2'd1;
	localparam logic [1:0] MODE_CONST_JERK  = 2'd2;
	localparam logic [1:0] MODE_RANDOM      = 2'd3;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [1:0] {VEC_V_OLD, VEC_NA, VEC_NJ, VEC_NV} vec_sel_t;
	typedef enum logic [1:0] {MS_SQ, MS_CLIP, MS_DP} mul_sel_t;
	typedef enum logic [1:0] {JOB_JR, JOB_CLIP, JOB_DP, JOB_DV} job_t;

	typedef struct packed {
		logic     load;
		logic     init;
		logic     mul;
		mul_sel_t msel;
		vec_sel_t vsel;
		logic     prep;
		logic     div_start;
		job_t     job;
		logic     commit;
	} lane_ctl_t;

	localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

	// Clamp a wide signed value into 32 bits.
	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > SAT_HI) begin
			r = 32'h7FFF_FFFF;
		end else if (x < SAT_LO) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/jerk_limited_kinematics_step.sv
// Top level of the jerk-limited kinematics step: configuration, sequencer,
// magnitude merge and square root. Depends on jlk_pkg, jlk_lane, jlk_isqrt.
`timescale 1ns / 1ps
`default_nettype none
// Each input item is either a load of one axis or one simulation tick, and
// every item yields exactly one result item holding the full state (position,
// velocity, acceleration and jerk for all axes) after it. A load goes straight
// to the output state. No new item is taken until a tick's result is
// registered and the block is back in idle: each axis owns a lane with a
// restoring divider, and every vector magnitude passes through one shared
// square root; the tick's length varies with how many of the three vector
// clips actually fire and whether the acceleration taper needs its own root.
// The lanes run in lock step, so the axis count does not change timing.
// A finished result sits in an output register, so the next item is taken
// while the previous result still waits. Configuration writes are always
// accepted and should only be issued while no item is in flight.
module jerk_limited_kinematics_step #(
	parameter int unsigned AXIS_COUNT = jlk_pkg::DEF_AXIS_COUNT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// load_jerk, load_accel, load_speed, load_place, random_jerk_x/y/z
	input  wire logic [223:0] s_axis_tdata,
	// command, axis
	input  wire logic [2:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// place_x/y/z, speed_x/y/z, accel_x/y/z, jerk_x/y/z
	output logic      [383:0] m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [30:0]  cfg_data
);
	localparam int unsigned AM = jlk_pkg::AXIS_MAX;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ, ST_SUM, ST_ROOT, ST_AM_DIFF, ST_AM_MUL, ST_AM_CMP,
		ST_AM_ROOT, ST_MUL, ST_PREP, ST_DIV, ST_WAIT, ST_COMMIT, ST_OUT
	} state_t;

	// Which part of the tick is running.
	typedef enum logic [2:0] {
		STEP_V, STEP_JR, STEP_NA, STEP_DP, STEP_DV, STEP_NJ, STEP_NV
	} step_t;

	state_t state_q, adv_state;
	step_t  step_q, adv_step;

	// Configuration registers.
	logic [30:0] jl_q, al_q, sl_q;
	logic [15:0] rate_q;
	logic [1:0]  mode_q [AM];

	// Tick working registers.
	logic [15:0] r_q;
	logic [63:0] den_q, t_q;
	logic [61:0] a2_q;
	logic [31:0] mag_q, amax_q, diff_q;
	logic        low_q;
	logic        out_valid_q;
	logic [383:0] out_data_q;

	logic        accept;
	logic        in_cmd;
	logic [1:0]  in_axis;
	jlk_pkg::lane_ctl_t ctl;
	logic [31:0] lim;
	logic [63:0] sq_sum;
	logic        root_start, root_done;
	logic [63:0] root_in;
	logic [31:0] root;
	logic [62:0] t_prod;
	logic [61:0] a2_prod;
	logic [31:0] rr_prod;
	logic [383:0] out_next;

	logic [63:0] lane_prod  [AM];
	logic        lane_done  [AM];
	logic [31:0] lane_place [AM];
	logic [31:0] lane_speed [AM];
	logic [31:0] lane_accel [AM];
	logic [31:0] lane_jerk  [AM];

	assign in_cmd        = s_axis_tuser[0];
	assign in_axis       = s_axis_tuser[2:1];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jl_q   <= 31'd65536;
			al_q   <= 31'd65536;
			sl_q   <= 31'd65536;
			rate_q <= 16'd100;
			for (int i = 0; i < AM; i++) begin
				mode_q[i] <= jlk_pkg::MODE_STILL;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jlk_pkg::REG_JERK_LIMIT:  jl_q      <= cfg_data;
				jlk_pkg::REG_ACCEL_LIMIT: al_q      <= cfg_data;
				jlk_pkg::REG_SPEED_LIMIT: sl_q      <= cfg_data;
				jlk_pkg::REG_TICK_RATE:   rate_q    <= cfg_data[15:0];
				jlk_pkg::REG_MODE_X:      mode_q[0] <= cfg_data[1:0];
				jlk_pkg::REG_MODE_Y:      mode_q[1] <= cfg_data[1:0];
				jlk_pkg::REG_MODE_Z:      mode_q[2] <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Lane control is decoded from the sequencer state and the accepted input.
	always_comb begin
		ctl.load      = accept && (in_cmd == jlk_pkg::CMD_LOAD);
		ctl.init      = accept && (in_cmd == jlk_pkg::CMD_TICK);
		ctl.mul       = (state_q == ST_SQ) || (state_q == ST_MUL);
		ctl.prep      = (state_q == ST_PREP);
		ctl.div_start = (state_q == ST_DIV);
		ctl.commit    = (state_q == ST_COMMIT);
		if (state_q == ST_SQ) begin
			ctl.msel = jlk_pkg::MS_SQ;
		end else if (step_q == STEP_DP) begin
			ctl.msel = jlk_pkg::MS_DP;
		end else begin
			ctl.msel = jlk_pkg::MS_CLIP;
		end
		case (step_q)
			STEP_NA: ctl.vsel = jlk_pkg::VEC_NA;
			STEP_NJ: ctl.vsel = jlk_pkg::VEC_NJ;
			STEP_NV: ctl.vsel = jlk_pkg::VEC_NV;
			default: ctl.vsel = jlk_pkg::VEC_V_OLD;
		endcase
		case (step_q)
			STEP_JR: ctl.job = jlk_pkg::JOB_JR;
			STEP_DP: ctl.job = jlk_pkg::JOB_DP;
			STEP_DV: ctl.job = jlk_pkg::JOB_DV;
			default: ctl.job = jlk_pkg::JOB_CLIP;
		endcase
		case (step_q)
			STEP_NJ: lim = {1'b0, jl_q};
			STEP_NV: lim = {1'b0, sl_q};
			default: lim = amax_q;
		endcase
	end

	// What follows once a part of the tick is finished.
	always_comb begin
		unique case (step_q)
			STEP_JR: begin adv_step = STEP_NA; adv_state = ST_SQ;      end
			STEP_NA: begin adv_step = STEP_DP; adv_state = ST_MUL;     end
			STEP_DP: begin adv_step = STEP_DV; adv_state = ST_PREP;    end
			STEP_DV: begin adv_step = STEP_NJ; adv_state = ST_SQ;      end
			STEP_NJ: begin adv_step = STEP_NV; adv_state = ST_SQ;      end
			STEP_NV: begin adv_step = STEP_NV; adv_state = ST_COMMIT;  end
			default: begin adv_step = STEP_V;  adv_state = ST_AM_DIFF; end
		endcase
	end

	// Merge stage: the sum of the lane squares, or the taper value, feeds the shared root.
	always_comb begin
		sq_sum = '0;
		for (int i = 0; i < AXIS_COUNT; i++) begin
			sq_sum = sq_sum + lane_prod[i];
		end
		root_start = (state_q == ST_SUM) || (state_q == ST_AM_CMP && !low_q && t_q < {2'b0, a2_q});
		root_in    = (state_q == ST_SUM) ? sq_sum : t_q;
		t_prod     = jl_q * diff_q;
		a2_prod    = al_q * al_q;
		rr_prod    = r_q * r_q;
	end

	jlk_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_in),
		.root     (root),
		.done     (root_done)
	);

	for (genvar g = 0; g < AM; g++) begin : g_lane
		if (g < AXIS_COUNT) begin : g_on
			jlk_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.sel      (in_axis == 2'(g)),
				.mode     (mode_q[g]),
				.ld_jerk  (s_axis_tdata[31:0]),
				.ld_accel (s_axis_tdata[63:32]),
				.ld_speed (s_axis_tdata[95:64]),
				.ld_place (s_axis_tdata[127:96]),
				.rnd_jerk (s_axis_tdata[128 + 32*g +: 32]),
				.rate     (r_q),
				.den      (den_q),
				.lim      (lim),
				.mag      (mag_q),
				.prod     (lane_prod[g]),
				.done     (lane_done[g]),
				.place    (lane_place[g]),
				.speed    (lane_speed[g]),
				.accel    (lane_accel[g]),
				.jerk     (lane_jerk[g])
			);
		end else begin : g_off
			assign lane_prod[g]  = '0;
			assign lane_done[g]  = 1'b0;
			assign lane_place[g] = '0;
			assign lane_speed[g] = '0;
			assign lane_accel[g] = '0;
			assign lane_jerk[g]  = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < AM; i++) begin
			out_next[32*i +: 32]       = lane_place[i];
			out_next[96 + 32*i +: 32]  = lane_speed[i];
			out_next[192 + 32*i +: 32] = lane_accel[i];
			out_next[288 + 32*i +: 32] = lane_jerk[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_V;
			r_q         <= 16'd1;
			den_q       <= '0;
			t_q         <= '0;
			a2_q        <= '0;
			mag_q       <= '0;
			amax_q      <= '0;
			diff_q      <= '0;
			low_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// The output state reloads the register itself when it frees up.
			if (out_valid_q && m_axis_tready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						r_q    <= (rate_q == 16'd0) ? 16'd1 : rate_q;
						step_q <= STEP_V;
						state_q <= (in_cmd == jlk_pkg::CMD_LOAD) ? ST_OUT : ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (root_done) begin
						mag_q <= root;
						if (step_q != STEP_V && root > lim) begin
							state_q <= ST_MUL;
						end else begin
							step_q  <= adv_step;
							state_q <= adv_state;
						end
					end
				end
				ST_AM_DIFF: begin
					low_q   <= (mag_q >= {1'b0, sl_q});
					diff_q  <= {1'b0, sl_q} - mag_q;
					den_q   <= {31'd0, rr_prod, 1'b0};
					state_q <= ST_AM_MUL;
				end
				ST_AM_MUL: begin
					t_q     <= {t_prod, 1'b0};
					a2_q    <= a2_prod;
					state_q <= ST_AM_CMP;
				end
				ST_AM_CMP: begin
					step_q <= STEP_JR;
					if (low_q) begin
						amax_q  <= '0;
						state_q <= ST_PREP;
					end else if (t_q >= {2'b0, a2_q}) begin
						amax_q  <= {1'b0, al_q};
						state_q <= ST_PREP;
					end else begin
						state_q <= ST_AM_ROOT;
					end
				end
				ST_AM_ROOT: begin
					if (root_done) begin
						amax_q  <= root;
						state_q <= ST_PREP;
					end
				end
				ST_MUL:  state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (lane_done[0]) begin
						step_q  <= adv_step;
						state_q <= adv_state;
					end
				end
				ST_COMMIT: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= out_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
endmodule
`default_nettype wire

>>> design/jlk_divider.sv
// Iterative unsigned 64-by-64 restoring divider, one quotient bit per cycle.
// Standalone; used by each lane.
`timescale 1ns / 1ps
`default_nettype none
module jlk_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic      [63:0] quotient,
	output logic             done
);
	logic [63:0] quo_q, rem_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [64:0] shifted, diff;

	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule
`default_nettype wire

>>> design/jlk_isqrt.sv
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Standalone; used by the top level for all vector magnitudes and the taper.
`timescale 1ns / 1ps
`default_nettype none
module jlk_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic      [31:0] root,
	output logic             done
);
	logic [63:0] x_q, r_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = r_q[31:0];
	assign done = done_q;
endmodule
`default_nettype wire

>>> design/jlk_lane.sv
// One axis of the kinematic state with its own multiplier and divider.
// Depends on jlk_pkg and jlk_divider; sequenced by the top level.
`timescale 1ns / 1ps
`default_nettype none
module jlk_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire jlk_pkg::lane_ctl_t ctl,
	input  wire logic              sel,
	input  wire logic [1:0]        mode,
	input  wire logic [31:0]       ld_jerk,
	input  wire logic [31:0]       ld_accel,
	input  wire logic [31:0]       ld_speed,
	input  wire logic [31:0]       ld_place,
	input  wire logic [31:0]       rnd_jerk,
	input  wire logic [15:0]       rate,
	input  wire logic [63:0]       den,
	input  wire logic [31:0]       lim,
	input  wire logic [31:0]       mag,
	output logic      [63:0]       prod,
	output logic                   done,
	output logic      [31:0]       place,
	output logic      [31:0]       speed,
	output logic      [31:0]       accel,
	output logic      [31:0]       jerk
);
	logic [31:0] place_q, speed_q, accel_q, jerk_q;
	logic [31:0] na_q, nj_q, nv_q;
	logic [63:0] prod_q, num_q;
	logic        neg_q;
	jlk_pkg::job_t     job_q;
	jlk_pkg::vec_sel_t vsel_q;

	logic [31:0]        vec;
	logic [32:0]        vec_ext, vec_abs;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;
	logic [63:0]        num_next, half, dvs, dvd, quo, qs;
	logic               div_done;

	always_comb begin
		case (ctl.vsel)
			jlk_pkg::VEC_NA: vec = na_q;
			jlk_pkg::VEC_NJ: vec = nj_q;
			jlk_pkg::VEC_NV: vec = nv_q;
			default:         vec = speed_q;
		endcase
		vec_ext = {vec[31], vec};
		vec_abs = vec[31] ? (~vec_ext + 33'd1) : vec_ext;
	end

	always_comb begin
		unique case (ctl.msel)
			jlk_pkg::MS_CLIP: begin
				mul_a = $signed(vec_abs);
				mul_b = $signed({1'b0, lim});
			end
			jlk_pkg::MS_DP: begin
				mul_a = $signed({speed_q[31], speed_q});
				mul_b = $signed({16'd0, rate, 1'b0});
			end
			default: begin
				mul_a = $signed(vec_abs);
				mul_b = $signed(vec_abs);
			end
		endcase
		mul_full = mul_a * mul_b;
	end

	always_comb begin
		unique case (ctl.job)
			jlk_pkg::JOB_JR:   num_next = {{32{jerk_q[31]}}, jerk_q};
			jlk_pkg::JOB_CLIP: num_next = prod_q;
			jlk_pkg::JOB_DP:   num_next = prod_q + {{32{accel_q[31]}}, accel_q};
			default:           num_next = {{32{accel_q[31]}}, accel_q}
				+ {{32{na_q[31]}}, na_q};
		endcase
		unique case (ctl.job)
			jlk_pkg::JOB_JR: begin
				half = {49'd0, rate[15:1]};
				dvs  = {48'd0, rate};
			end
			jlk_pkg::JOB_CLIP: begin
				half = '0;
				dvs  = {32'd0, mag};
			end
			jlk_pkg::JOB_DP: begin
				half = {1'b0, den[63:1]};
				dvs  = den;
			end
			default: begin
				half = {48'd0, rate};
				dvs  = {47'd0, rate, 1'b0};
			end
		endcase
		// Round half away from zero (a clip truncates, its half being zero) by working on the magnitude.
		dvd = num_q[63] ? (half - num_q) : (num_q + half);
		qs  = neg_q ? (~quo + 64'd1) : quo;
	end

	jlk_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_q <= '0;
			speed_q <= '0;
			accel_q <= '0;
			jerk_q  <= '0;
		end else begin
			if (ctl.load && sel) begin
				place_q <= ld_place;
				speed_q <= ld_speed;
				accel_q <= (mode == jlk_pkg::MODE_STILL) ? '0 : ld_accel;
				jerk_q  <= (mode == jlk_pkg::MODE_STILL || mode == jlk_pkg::MODE_CONST_ACCEL)
					? '0 : ld_jerk;
			end
			if (div_done && job_q == jlk_pkg::JOB_DP) begin
				place_q <= jlk_pkg::sat32($signed({{32{place_q[31]}}, place_q}) + $signed(qs));
			end
			if (ctl.commit) begin
				speed_q <= nv_q;
				accel_q <= na_q;
				jerk_q  <= nj_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			nj_q <= (mode == jlk_pkg::MODE_RANDOM) ? rnd_jerk : jerk_q;
		end
		if (ctl.mul) begin
			prod_q <= mul_full[63:0];
		end
		if (ctl.prep) begin
			num_q <= num_next;
		end
		if (ctl.div_start) begin
			// A clip divides the magnitude, so its sign comes from the component.
			neg_q  <= (ctl.job == jlk_pkg::JOB_CLIP) ? vec[31] : num_q[63];
			job_q  <= ctl.job;
			vsel_q <= ctl.vsel;
		end
		if (div_done) begin
			case (job_q)
				jlk_pkg::JOB_JR: begin
					na_q <= jlk_pkg::sat32($signed({{32{accel_q[31]}}, accel_q}) + $signed(qs));
				end
				jlk_pkg::JOB_CLIP: begin
					case (vsel_q)
						jlk_pkg::VEC_NA: na_q <= qs[31:0];
						jlk_pkg::VEC_NJ: nj_q <= qs[31:0];
						default:         nv_q <= qs[31:0];
					endcase
				end
				jlk_pkg::JOB_DV: begin
					nv_q <= jlk_pkg::sat32($signed({{32{speed_q[31]}}, speed_q}) + $signed(qs));
				end
				default: ;
			endcase
		end
	end

	assign prod  = prod_q;
	assign done  = div_done;
	assign place = place_q;
	assign speed = speed_q;
	assign accel = accel_q;
	assign jerk  = jerk_q;
endmodule
`default_nettype wire
